// ===== hw/rtl/pkic_pkg.sv =====
// Shared types, widths and codes of the power key and idle controller.
package pkic_pkg;

  localparam int unsigned HoldBits     = 16;
  localparam int unsigned IdleBits     = 32;
  localparam int unsigned HoldCfgBits  = 16;
  localparam int unsigned TimeoutBits  = 32;
  localparam int unsigned WakeBits     = 16;
  localparam int unsigned ElapsedBits  = 16;
  localparam int unsigned IdleOutBits  = 32;
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned CfgDataBits  = 32;
  localparam int unsigned HoldCmpBits  = (HoldBits > HoldCfgBits) ? HoldBits : HoldCfgBits;
  localparam int unsigned IdleCmpBits  = (IdleBits > TimeoutBits) ? IdleBits : TimeoutBits;

  localparam logic [HoldCfgBits-1:0] SleepHoldRst    = HoldCfgBits'(10);
  localparam logic [HoldCfgBits-1:0] RestartHoldRst  = HoldCfgBits'(20);
  localparam logic [HoldCfgBits-1:0] ShutdownHoldRst = HoldCfgBits'(30);
  localparam logic [TimeoutBits-1:0] TimeoutRst      = TimeoutBits'(30000);
  localparam logic [WakeBits-1:0]    WakeWindowRst   = WakeBits'(1000);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SLEEP_HOLD    = 3'd0,
    CFG_RESTART_HOLD  = 3'd1,
    CFG_SHUTDOWN_HOLD = 3'd2,
    CFG_SCREEN_TMO    = 3'd3,
    CFG_WAKE_WINDOW   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_NONE    = 2'd0,
    REQ_SLEEP   = 2'd1,
    REQ_RESTART = 2'd2
  } req_e;

  typedef struct packed {
    logic                   key_down;
    logic                   activity_seen;
    logic [ElapsedBits-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic                   display_on;
    logic                   went_to_sleep;
    logic                   woke_up;
    logic [1:0]             hold_request;
    logic                   power_hold;
    logic [IdleOutBits-1:0] idle_time_ms;
  } out_item_t;

  typedef struct packed {
    logic [HoldCfgBits-1:0] sleep_hold;
    logic [HoldCfgBits-1:0] restart_hold;
    logic [HoldCfgBits-1:0] shutdown_hold;
  } hold_cfg_t;

  typedef struct packed {
    logic [TimeoutBits-1:0] screen_timeout;
    logic [WakeBits-1:0]    wake_window;
  } idle_cfg_t;

  typedef struct packed {
    logic press;
    req_e request;
    logic power_hold;
  } key_stat_t;

  typedef struct packed {
    logic                   display_on;
    logic                   went_to_sleep;
    logic                   woke_up;
    logic [IdleOutBits-1:0] idle_time_ms;
  } idle_stat_t;

endpackage

// ===== hw/rtl/pkic_if.sv =====
// Valid/ready channels for poll items and result items.
interface pkic_in_if;
  logic               valid;
  logic               ready;
  pkic_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface pkic_out_if;
  logic                valid;
  logic                ready;
  pkic_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== hw/rtl/pkic_key_ctrl.sv =====
// Power key boot guard, hold counter, request code and power latch.
module pkic_key_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                key_down_i,
  input  pkic_pkg::hold_cfg_t cfg_i,
  output pkic_pkg::key_stat_t stat_o
);

  localparam logic [pkic_pkg::HoldBits-1:0] HoldMax = '1;

  logic                          armed_q, armed_d;
  logic                          was_down_q, was_down_d;
  logic [pkic_pkg::HoldBits-1:0] hold_q, hold_d, hold_inc;
  pkic_pkg::req_e                req_q, req_d;
  logic                          pwr_q, pwr_d;
  logic                          press;

  always_comb begin
    armed_d    = armed_q;
    was_down_d = was_down_q;
    hold_d     = hold_q;
    req_d      = req_q;
    pwr_d      = pwr_q;
    press      = 1'b0;
    hold_inc   = (hold_q == HoldMax) ? hold_q : hold_q + pkic_pkg::HoldBits'(1);
    if (key_down_i) begin
      if (armed_q) begin
        press  = !was_down_q;
        hold_d = hold_inc;
        if (pkic_pkg::HoldCmpBits'(hold_d) >= pkic_pkg::HoldCmpBits'(cfg_i.sleep_hold)) begin
          if (pkic_pkg::HoldCmpBits'(hold_d) < pkic_pkg::HoldCmpBits'(cfg_i.restart_hold)) begin
            req_d = pkic_pkg::REQ_SLEEP;
          end else if (pkic_pkg::HoldCmpBits'(hold_d)
                       < pkic_pkg::HoldCmpBits'(cfg_i.shutdown_hold)) begin
            req_d = pkic_pkg::REQ_RESTART;
          end else begin
            pwr_d = 1'b0;
          end
        end
      end
      was_down_d = 1'b1;
    end else begin
      armed_d    = 1'b1;
      hold_d     = '0;
      was_down_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      was_down_q <= 1'b0;
      hold_q     <= '0;
      req_q      <= pkic_pkg::REQ_NONE;
      pwr_q      <= 1'b1;
    end else if (step_i) begin
      armed_q    <= armed_d;
      was_down_q <= was_down_d;
      hold_q     <= hold_d;
      req_q      <= req_d;
      pwr_q      <= pwr_d;
    end
  end

  assign stat_o.press      = press;
  assign stat_o.request    = req_d;
  assign stat_o.power_hold = pwr_d;

  a_latch_stays_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pwr_q |=> !pwr_q) else $error("power latch re-armed without reset");
  a_request_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_q != pkic_pkg::REQ_NONE) |=> (req_q != pkic_pkg::REQ_NONE))
    else $error("hold request cleared without reset");
  a_unarmed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !armed_q |-> (hold_q == '0)) else $error("hold counter ran before key was armed");

endmodule

// ===== hw/rtl/pkic_idle_ctrl.sv =====
// Saturating idle timer with display blank and wake decisions.
module pkic_idle_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic                             activity_i,
  input  logic [pkic_pkg::ElapsedBits-1:0] elapsed_i,
  input  pkic_pkg::idle_cfg_t              cfg_i,
  output pkic_pkg::idle_stat_t             stat_o
);

  localparam logic [pkic_pkg::IdleBits-1:0]    IdleMax    = '1;
  localparam logic [pkic_pkg::IdleOutBits-1:0] IdleOutMax = '1;

  logic [pkic_pkg::IdleBits-1:0] idle_q, idle_d;
  logic [pkic_pkg::IdleBits:0]   sum;
  logic                          awake_q, awake_d;
  logic                          slept, woke;

  always_comb begin
    sum     = {1'b0, idle_q} + (pkic_pkg::IdleBits + 1)'(elapsed_i);
    awake_d = awake_q;
    slept   = 1'b0;
    woke    = 1'b0;
    if (activity_i) begin
      idle_d = '0;
    end else if (sum[pkic_pkg::IdleBits]) begin
      idle_d = IdleMax;
    end else begin
      idle_d = sum[pkic_pkg::IdleBits-1:0];
    end
    if (awake_q) begin
      if (pkic_pkg::IdleCmpBits'(idle_d) > pkic_pkg::IdleCmpBits'(cfg_i.screen_timeout)) begin
        awake_d = 1'b0;
        slept   = 1'b1;
      end
    end else if (pkic_pkg::IdleCmpBits'(idle_d) < pkic_pkg::IdleCmpBits'(cfg_i.wake_window)) begin
      awake_d = 1'b1;
      woke    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q  <= '0;
      awake_q <= 1'b1;
    end else if (step_i) begin
      idle_q  <= idle_d;
      awake_q <= awake_d;
    end
  end

  assign stat_o.display_on    = awake_d;
  assign stat_o.went_to_sleep = slept;
  assign stat_o.woke_up       = woke;
  assign stat_o.idle_time_ms  =
    (pkic_pkg::IdleCmpBits'(idle_d) > pkic_pkg::IdleCmpBits'(IdleOutMax))
      ? IdleOutMax : pkic_pkg::IdleOutBits'(idle_d);

  a_zero_idle_wakes_nothing_awake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && activity_i) |=> (idle_q == '0)) else $error("activity did not clear idle time");

endmodule

// ===== hw/rtl/power_key_long_press_idle_controller.sv =====
// Top level of the power key long-press and display idle controller.
// One poll item in, one result item out. A poll is taken into an input
// register, worked through the key and idle logic once the result register
// can take a new item, and written to that result register. A new poll can
// be accepted every cycle while the result consumer keeps up (one item per
// clock, as each poll makes a single key/idle update to the controller
// state). The result register lets the next poll move up while a finished
// result still waits for its consumer. The boot guard ignores the power key
// until it has been seen released once; a held, armed key counts up and
// raises a sleep request, then a restart request, then drops the power
// latch. Requests and the latch only clear on reset. Write the threshold
// registers only while no poll is in flight; unknown register indexes are
// ignored.
module power_key_long_press_idle_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pkic_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [pkic_pkg::CfgDataBits-1:0] cfg_data_i,
  pkic_in_if.sink                          in_i,
  pkic_out_if.source                       out_o
);

  // Configuration registers
  pkic_pkg::hold_cfg_t hold_cfg_q;
  pkic_pkg::idle_cfg_t idle_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cfg_q.sleep_hold     <= pkic_pkg::SleepHoldRst;
      hold_cfg_q.restart_hold   <= pkic_pkg::RestartHoldRst;
      hold_cfg_q.shutdown_hold  <= pkic_pkg::ShutdownHoldRst;
      idle_cfg_q.screen_timeout <= pkic_pkg::TimeoutRst;
      idle_cfg_q.wake_window    <= pkic_pkg::WakeWindowRst;
    end else if (cfg_we_i) begin
      unique case (pkic_pkg::cfg_idx_e'(cfg_idx_i))
        pkic_pkg::CFG_SLEEP_HOLD:
          hold_cfg_q.sleep_hold <= cfg_data_i[pkic_pkg::HoldCfgBits-1:0];
        pkic_pkg::CFG_RESTART_HOLD:
          hold_cfg_q.restart_hold <= cfg_data_i[pkic_pkg::HoldCfgBits-1:0];
        pkic_pkg::CFG_SHUTDOWN_HOLD:
          hold_cfg_q.shutdown_hold <= cfg_data_i[pkic_pkg::HoldCfgBits-1:0];
        pkic_pkg::CFG_SCREEN_TMO:
          idle_cfg_q.screen_timeout <= cfg_data_i[pkic_pkg::TimeoutBits-1:0];
        pkic_pkg::CFG_WAKE_WINDOW:
          idle_cfg_q.wake_window <= cfg_data_i[pkic_pkg::WakeBits-1:0];
        default: ;
      endcase
    end
  end

  // Input register and result register handshake
  logic                 in_vld_q, in_vld_d;
  pkic_pkg::in_item_t   in_q;
  logic                 res_vld_q, res_vld_d;
  pkic_pkg::out_item_t  res_q;
  logic                 advance;   // result register can take a new item
  logic                 step;      // the held poll updates state this cycle
  logic                 in_take;

  assign advance    = !res_vld_q || out_o.ready;
  assign step       = in_vld_q && advance;
  assign in_i.ready = !in_vld_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    res_vld_d = res_vld_q;
    if (step) begin
      res_vld_d = 1'b1;
    end else if (out_o.ready) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_i.item;
    end
  end

  // Key handling first, then idle timing; a press edge counts as activity
  pkic_pkg::key_stat_t  key_stat;
  pkic_pkg::idle_stat_t idle_stat;

  pkic_key_ctrl u_key (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .key_down_i (in_q.key_down),
    .cfg_i      (hold_cfg_q),
    .stat_o     (key_stat)
  );

  pkic_idle_ctrl u_idle (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .activity_i (in_q.activity_seen || key_stat.press),
    .elapsed_i  (in_q.elapsed_ms),
    .cfg_i      (idle_cfg_q),
    .stat_o     (idle_stat)
  );

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q.display_on    <= idle_stat.display_on;
      res_q.went_to_sleep <= idle_stat.went_to_sleep;
      res_q.woke_up       <= idle_stat.woke_up;
      res_q.hold_request  <= key_stat.request;
      res_q.power_hold    <= key_stat.power_hold;
      res_q.idle_time_ms  <= idle_stat.idle_time_ms;
    end
  end

  assign out_o.valid = res_vld_q;
  assign out_o.item  = res_q;

  a_sleep_wake_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> !(res_q.went_to_sleep && res_q.woke_up))
    else $error("result both blanked and woke the display");
  a_sleep_blanks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.went_to_sleep) |-> !res_q.display_on)
    else $error("display reported awake on the poll that blanked it");
  a_no_lost_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> in_vld_q)
    else $error("held poll dropped while result register was full");

endmodule

// ===== tb/sv/power_key_long_press_idle_controller_test.sv =====
// Self-checking testbench for the power key long-press and display idle controller.
module power_key_long_press_idle_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pkic_pkg::*;

  localparam int unsigned     ClkHalfNs   = 6;
  localparam int unsigned     ResetCycles = 5;
  localparam int unsigned     PhasePolls  = 200;
  // Length of the closing long hold.
  localparam int unsigned     SoakPolls   = 30;
  localparam int unsigned     MaxHoldRun  = 40;
  localparam int unsigned     PrintLimit  = 40;
  localparam int unsigned     TailCycles  = 8;
  localparam longint unsigned RunLimitNs  = 64'd12_000_000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  pkic_in_if  poll_ch ();
  pkic_out_if result_ch ();

  power_key_long_press_idle_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (poll_ch),
    .out_o      (result_ch)
  );

  // Polls still to be offered, and the results that accepted polls must produce.
  in_item_t  pending_polls[$];
  out_item_t awaited_results[$];

  // Percentage of cycles in which the poll sender and the result receiver hold back.
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;

  int unsigned err_cnt;
  int unsigned result_cnt;

  // Predicted controller state.
  logic                armed;
  logic                key_held;
  logic [HoldBits-1:0] hold_polls;
  req_e                latched_req;
  logic                power_on;
  logic                awake;
  logic [IdleBits-1:0] idle_acc;

  // Mirror of the configuration registers.
  logic [HoldCfgBits-1:0] sleep_thr;
  logic [HoldCfgBits-1:0] restart_thr;
  logic [HoldCfgBits-1:0] shutdown_thr;
  logic [TimeoutBits-1:0] blank_after_ms;
  logic [WakeBits-1:0]    wake_below_ms;

  always begin
    clk_i = 1'b0;
    #ClkHalfNs;
    clk_i = 1'b1;
    #ClkHalfNs;
  end

  // Work one poll through the key logic and then the idle logic, and return the
  // result item that the controller must give for it.
  function automatic out_item_t advance_controller(input in_item_t poll);
    out_item_t           res;
    logic                active;
    logic [IdleBits:0]   sum;
    res    = '0;
    active = poll.activity_seen;
    if (poll.key_down) begin
      // A key held since boot is ignored until it has been let go once.
      if (armed) begin
        if (!key_held) begin
          active = 1'b1;
        end
        if (hold_polls != '1) begin
          hold_polls = hold_polls + HoldBits'(1);
        end
        // Apply the thresholds exactly as ordered, even when they are out of order.
        if (hold_polls >= sleep_thr) begin
          if (hold_polls < restart_thr) begin
            latched_req = REQ_SLEEP;
          end else if (hold_polls < shutdown_thr) begin
            latched_req = REQ_RESTART;
          end else begin
            power_on = 1'b0;
          end
        end
      end
      key_held = 1'b1;
    end else begin
      armed      = 1'b1;
      hold_polls = '0;
      key_held   = 1'b0;
    end

    // Clear on activity, else add the elapsed time and saturate.
    if (active) begin
      idle_acc = '0;
    end else begin
      sum      = {1'b0, idle_acc} + (IdleBits + 1)'(poll.elapsed_ms);
      idle_acc = sum[IdleBits] ? '1 : sum[IdleBits-1:0];
    end

    // A zero wake window means a blanked display stays blank.
    if (awake) begin
      if (idle_acc > blank_after_ms) begin
        awake             = 1'b0;
        res.went_to_sleep = 1'b1;
      end
    end else if (idle_acc < IdleBits'(wake_below_ms)) begin
      awake       = 1'b1;
      res.woke_up = 1'b1;
    end

    res.display_on   = awake;
    res.hold_request = latched_req;
    res.power_hold   = power_on;
    res.idle_time_ms = IdleOutBits'(idle_acc);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_cnt < PrintLimit) begin
      $display("%0t ns: result %0d %s: got 0x%0h, expected 0x%0h",
               $time, result_cnt, what, got, want);
    end
    err_cnt++;
  endtask

  // Driver: predict each poll as it is accepted, then offer the next one unless
  // the sender chooses to idle. Hold valid and the item while the block stalls.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      poll_ch.valid <= 1'b0;
    end else begin
      if (poll_ch.valid && poll_ch.ready) begin
        awaited_results.push_back(advance_controller(poll_ch.item));
        void'(pending_polls.pop_front());
      end
      if (!poll_ch.valid || poll_ch.ready) begin
        if (pending_polls.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          poll_ch.valid <= 1'b1;
          poll_ch.item  <= pending_polls[0];
        end else begin
          poll_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction, field by
  // field, and stall at random.
  always @(posedge clk_i) begin : result_monitor
    out_item_t want;
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no poll outstanding",
                          result_ch.item.idle_time_ms, '0);
        end else begin
          want = awaited_results.pop_front();
          if (result_ch.item.display_on !== want.display_on)
            report_mismatch("display_on", 32'(result_ch.item.display_on),
                            32'(want.display_on));
          if (result_ch.item.went_to_sleep !== want.went_to_sleep)
            report_mismatch("went_to_sleep", 32'(result_ch.item.went_to_sleep),
                            32'(want.went_to_sleep));
          if (result_ch.item.woke_up !== want.woke_up)
            report_mismatch("woke_up", 32'(result_ch.item.woke_up), 32'(want.woke_up));
          if (result_ch.item.hold_request !== want.hold_request)
            report_mismatch("hold_request", 32'(result_ch.item.hold_request),
                            32'(want.hold_request));
          if (result_ch.item.power_hold !== want.power_hold)
            report_mismatch("power_hold", 32'(result_ch.item.power_hold),
                            32'(want.power_hold));
          if (result_ch.item.idle_time_ms !== want.idle_time_ms)
            report_mismatch("idle_time_ms", result_ch.item.idle_time_ms,
                            want.idle_time_ms);
        end
        result_cnt++;
      end
      result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Write one register at a clock edge and track it in the mirror. Unknown
  // indexes are dropped by the block, so leave the mirror alone for them.
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SLEEP_HOLD:    sleep_thr      = data[HoldCfgBits-1:0];
      CFG_RESTART_HOLD:  restart_thr    = data[HoldCfgBits-1:0];
      CFG_SHUTDOWN_HOLD: shutdown_thr   = data[HoldCfgBits-1:0];
      CFG_SCREEN_TMO:    blank_after_ms = data[TimeoutBits-1:0];
      CFG_WAKE_WINDOW:   wake_below_ms  = data[WakeBits-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [HoldCfgBits-1:0] sleep_v,
                               input logic [HoldCfgBits-1:0] restart_v,
                               input logic [HoldCfgBits-1:0] shutdown_v,
                               input logic [TimeoutBits-1:0] timeout_v,
                               input logic [WakeBits-1:0]    wake_v);
    write_reg(CFG_SLEEP_HOLD,    CfgDataBits'(sleep_v));
    write_reg(CFG_RESTART_HOLD,  CfgDataBits'(restart_v));
    write_reg(CFG_SHUTDOWN_HOLD, CfgDataBits'(shutdown_v));
    write_reg(CFG_SCREEN_TMO,    CfgDataBits'(timeout_v));
    write_reg(CFG_WAKE_WINDOW,   CfgDataBits'(wake_v));
  endtask

  // Short thresholds keep the hold runs brief; now and then a huge timeout.
  task automatic random_setting();
    apply_setting(HoldCfgBits'($urandom_range(12, 1)), HoldCfgBits'($urandom_range(24, 1)),
                  HoldCfgBits'($urandom_range(36, 4)),
                  ($urandom_range(3) == 0) ? TimeoutBits'($urandom)
                                           : TimeoutBits'($urandom_range(90000)),
                  WakeBits'($urandom_range(4000)));
  endtask

  task automatic queue_poll(input logic key, input logic act,
                            input logic [ElapsedBits-1:0] el);
    in_item_t poll;
    poll.key_down      = key;
    poll.activity_seen = act;
    poll.elapsed_ms    = el;
    pending_polls.push_back(poll);
  endtask

  // Favour the ends of the range and short gaps, but cover every bit.
  function automatic logic [ElapsedBits-1:0] pick_elapsed();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return ElapsedBits'($urandom_range(200));
      default: return ElapsedBits'($urandom);
    endcase
  endfunction

  task automatic queue_run(input logic key, input int unsigned count);
    repeat (count) queue_poll(key, $urandom_range(4) == 0, pick_elapsed());
  endtask

  // Wait until every poll has been taken and every result checked.
  task automatic await_drain();
    do @(negedge clk_i);
    while (pending_polls.size() != 0 || awaited_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly press gestures (a short release to arm, then a hold of up to three polls
  // past the shutdown threshold, capped at MaxHoldRun), with raw noise polls mixed in.
  task automatic run_phase(input int unsigned polls_n);
    int unsigned hold_max;
    int unsigned added;
    int unsigned run;
    logic [$bits(in_item_t)-1:0] noise;
    hold_max = (int'(shutdown_thr) + 3 > MaxHoldRun) ? MaxHoldRun : int'(shutdown_thr) + 3;
    added    = 0;
    @(negedge clk_i);
    while (added < polls_n) begin
      if ($urandom_range(9) == 0) begin
        noise = $bits(in_item_t)'($urandom);
        pending_polls.push_back(noise);
        added++;
      end else begin
        run = $urandom_range(3, 1);
        queue_run(1'b0, run);
        added += run;
        run = $urandom_range(hold_max, 1);
        queue_run(1'b1, run);
        added += run;
      end
    end
    await_drain();
  endtask

  initial begin
    int spare;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    poll_ch.valid   = 1'b0;
    poll_ch.item    = '0;
    result_ch.ready = 1'b0;
    err_cnt         = 0;
    result_cnt      = 0;

    armed          = 1'b0;
    key_held       = 1'b0;
    hold_polls     = '0;
    latched_req    = REQ_NONE;
    power_on       = 1'b1;
    awake          = 1'b1;
    idle_acc       = '0;
    sleep_thr      = SleepHoldRst;
    restart_thr    = RestartHoldRst;
    shutdown_thr   = ShutdownHoldRst;
    blank_after_ms = TimeoutRst;
    wake_below_ms  = WakeWindowRst;

    // Sender idles lightly, receiver heavily.
    src_idle_pct  = 14;
    sink_idle_pct = 78;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset thresholds: boot guard, activity flag, blanking and waking.
    @(negedge clk_i);
    queue_poll(1'b1, 1'b0, '0);               // held since boot: no count, no activity
    queue_poll(1'b1, 1'b1, '1);               // the activity flag still clears idle
    queue_poll(1'b1, 1'b0, '1);               // idle passes the timeout: blank
    queue_poll(1'b0, 1'b0, 16'd1);            // first release arms the key
    queue_poll(1'b1, 1'b0, '1);               // press edge is activity: wake
    queue_poll(1'b1, 1'b0, 16'h5555);
    queue_poll(1'b1, 1'b0, 16'hAAAA);         // idle reaches 65535: blank again
    queue_poll(1'b0, 1'b1, '0);               // activity wakes it
    await_drain();

    // Short holds, zero timeout and zero wake window.
    apply_setting(HoldCfgBits'(2), HoldCfgBits'(3), '1, '0, '0);
    @(negedge clk_i);
    queue_poll(1'b0, 1'b0, 16'd7);            // any idle blanks
    queue_poll(1'b1, 1'b0, '0);               // press edge clears idle, yet no wake
    queue_poll(1'b1, 1'b0, '0);               // sleep request
    queue_poll(1'b1, 1'b0, '0);               // restart request
    queue_poll(1'b1, 1'b0, '1);
    queue_poll(1'b0, 1'b1, '1);               // activity alone cannot wake either
    await_drain();

    // Indexes beyond the last register must be ignored.
    for (spare = int'(CFG_WAKE_WINDOW) + 1; spare < (1 << CfgIdxBits); spare++) begin
      write_reg(CfgIdxBits'(spare), $urandom);
    end
    apply_setting(SleepHoldRst, RestartHoldRst, ShutdownHoldRst, TimeoutRst, WakeWindowRst);
    run_phase(PhasePolls);
    random_setting();
    run_phase(PhasePolls);

    // Swap: sender idles heavily, receiver lightly.
    src_idle_pct  = 78;
    sink_idle_pct = 14;
    apply_setting('1, '1, '1, '1, '1);
    run_phase(PhasePolls);
    random_setting();
    run_phase(PhasePolls);

    // No idling on either side from here on.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    apply_setting(HoldCfgBits'(1), HoldCfgBits'(2), HoldCfgBits'(3), '0, '1);
    run_phase(PhasePolls);
    apply_setting(HoldCfgBits'(5), HoldCfgBits'(3), HoldCfgBits'(2),
                  TimeoutBits'(200), WakeBits'(50));
    run_phase(PhasePolls);
    random_setting();
    run_phase(PhasePolls);

    // Hold the key through a long run of full gaps against thresholds near the
    // top of their range.
    apply_setting(HoldCfgBits'(16'hFFFD), HoldCfgBits'(16'hFFFE), '1,
                  TimeoutBits'(32'hFFFF_FFFE), '1);
    @(negedge clk_i);
    queue_poll(1'b0, 1'b0, '1);
    repeat (SoakPolls) queue_poll(1'b1, 1'b0, '1);
    queue_poll(1'b0, 1'b1, '0);
    await_drain();

    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Drop the run if the stimulus or the results never drain.
  initial begin
    #RunLimitNs;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
